// ===== sv/b64e_pkg.sv =====
// b64e_pkg: types, constants and the sextet-to-character function
// for the base64 stream encoder
// no dependencies
package b64e_pkg;

    localparam logic [1:0] PHASE_ZERO = 2'd0;
    localparam logic [1:0] PHASE_ONE  = 2'd1;
    localparam logic [1:0] PHASE_TWO  = 2'd2;

    localparam logic [6:0] PAD_CHAR   = 7'd61;
    localparam logic [6:0] PLUS_CHAR  = 7'd43;
    localparam logic [6:0] SLASH_CHAR = 7'd47;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } b64e_in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_text;
    } b64e_out_t;

    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [3:0]      pad;
        logic [1:0]      last_idx;
        logic            fin;
    } b64e_job_t;

    function automatic logic [6:0] b64e_char(input logic [5:0] s);
        logic [6:0] c;
        if (s < 6'd26)
        begin
            c = 7'd65 + {1'b0, s};
        end
        else if (s < 6'd52)
        begin
            c = 7'd97 + ({1'b0, s} - 7'd26);
        end
        else if (s < 6'd62)
        begin
            c = 7'd48 + ({1'b0, s} - 7'd52);
        end
        else if (s == 6'd62)
        begin
            c = PLUS_CHAR;
        end
        else
        begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

// ===== sv/b64e_front.sv =====
// b64e_front: accepts bytes, tracks group phase and carry bits,
// and builds one character job per byte; depends on b64e_pkg
module b64e_front
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  b64e_in_t  byte_data,
    output logic      job_valid,
    input  logic      job_ready,
    output b64e_job_t job_data
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       accept;
    logic [7:0] b;
    logic       last;

    assign byte_ready = job_ready;
    assign job_valid  = byte_valid;
    assign accept     = byte_valid && job_ready;
    assign b          = byte_data.data_byte;
    assign last       = byte_data.last_byte;

    always_comb
    begin
        job_data   = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        case (phase_reg)
            PHASE_ONE:
            begin
                job_data.sextet[0] = {carry_reg[1:0], b[7:4]};
                if (last)
                begin
                    job_data.sextet[1] = {b[3:0], 2'b00};
                    job_data.pad[2]    = 1'b1;
                    job_data.last_idx  = 2'd2;
                    job_data.fin       = 1'b1;
                    phase_next         = PHASE_ZERO;
                    carry_next         = 4'd0;
                end
                else
                begin
                    phase_next = PHASE_TWO;
                    carry_next = b[3:0];
                end
            end
            PHASE_TWO:
            begin
                job_data.sextet[0] = {carry_reg, b[7:6]};
                job_data.sextet[1] = b[5:0];
                job_data.last_idx  = 2'd1;
                job_data.fin       = last;
                phase_next         = PHASE_ZERO;
                carry_next         = 4'd0;
            end
            default:
            begin
                job_data.sextet[0] = b[7:2];
                if (last)
                begin
                    job_data.sextet[1] = {b[1:0], 4'b0000};
                    job_data.pad[2]    = 1'b1;
                    job_data.pad[3]    = 1'b1;
                    job_data.last_idx  = 2'd3;
                    job_data.fin       = 1'b1;
                    phase_next         = PHASE_ZERO;
                    carry_next         = 4'd0;
                end
                else
                begin
                    phase_next = PHASE_ONE;
                    carry_next = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_ZERO;
            carry_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== sv/b64e_queue.sv =====
// b64e_queue: short job queue between front and back
// depends on b64e_pkg
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  b64e_job_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output b64e_job_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64e_job_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/b64e_back.sv =====
// b64e_back: walks each job into the output register one character per cycle
// while char_ready allows; depends on b64e_pkg
module b64e_back
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  b64e_job_t job_data,
    output logic      char_valid,
    input  logic      char_ready,
    output b64e_out_t char_data
);

    b64e_job_t  job_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    b64e_out_t  out_reg;
    logic       load;
    logic       emit;
    logic       last_slot;
    b64e_out_t  slot;

    assign load       = !out_valid_reg || char_ready;
    assign emit       = busy_reg && load;
    assign last_slot  = idx_reg == job_reg.last_idx;
    assign job_ready  = !busy_reg || (emit && last_slot);
    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

    always_comb
    begin
        slot.out_char    = job_reg.pad[idx_reg] ? PAD_CHAR : b64e_char(job_reg.sextet[idx_reg]);
        slot.end_of_text = last_slot && job_reg.fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= emit;
            end
            if (job_valid && job_ready)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (emit)
            begin
                if (last_slot)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job_data;
        end
        if (emit)
        begin
            out_reg <= slot;
        end
    end

endmodule

// ===== sv/base64_stream_encoder_core.sv =====
// base64_stream_encoder_core: top level, front + job queue + back
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// channel  dir  handshake              payload
// byte     in   byte_valid/byte_ready  byte_data (data_byte, last_byte)
// char     out  char_valid/char_ready  char_data (out_char, end_of_text)
//
// a byte is taken while the queue has room; its first character passes through
// the queue entry, the job register and the output register
// the back end emits one character per cycle while char_ready allows, and a byte
// yields one to four characters, about 1.33 on average inside a message
// reset is asynchronous, active low, and clears phase, queue and output valid
// a stalled output holds its character; the queue absorbs up to QUEUE_DEPTH bytes
module base64_stream_encoder_core
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  b64e_in_t  byte_data,
    output logic      char_valid,
    input  logic      char_ready,
    output b64e_out_t char_data
);

    logic      fq_valid, fq_ready;
    b64e_job_t fq_data;
    logic      qb_valid, qb_ready;
    b64e_job_t qb_data;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job_data   (fq_data)
    );

    b64e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job_data   (qb_data),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data)
    );

endmodule

// ===== sv/b64e_checker.sv =====
// b64e_checker: port-level assertions for base64_stream_encoder_core
// depends on b64e_pkg; bound to the top level below
module b64e_checker
    import b64e_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_ready,
    input b64e_in_t  byte_data,
    input logic      char_valid,
    input logic      char_ready,
    input b64e_out_t char_data
);

    logic [6:0] c;
    assign c = char_data.out_char;

    // stalled input transaction stays valid with its payload
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
        else $error("byte transaction changed while stalled");

    // stalled transaction stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid)
        else $error("char_valid dropped while stalled");

    // stalled transaction keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> $stable(char_data))
        else $error("char_data changed while stalled");

    // only alphabet or pad characters
    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (c == PLUS_CHAR || c == SLASH_CHAR || c == PAD_CHAR
            || (c >= 7'd48 && c <= 7'd57) || (c >= 7'd65 && c <= 7'd90)
            || (c >= 7'd97 && c <= 7'd122)))
        else $error("character outside base64 alphabet");

    // nothing offered right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !char_valid)
        else $error("char_valid high after reset");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
);

// ===== sim/base64_stream_encoder_core_tb.sv =====
// base64_stream_encoder_core_tb: self-checking bench for the base64 stream encoder
// sends byte messages through the valid/ready input, predicts the character stream
// and compares every output transaction; depends on b64e_pkg and the encoder rtl
`timescale 1ns / 1ps

module base64_stream_encoder_core_tb;
    import b64e_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 20;
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_ready;
    b64e_in_t  byte_data;
    logic      char_valid;
    logic      char_ready;
    b64e_out_t char_data;

    logic [1:0] enc_phase;
    logic [3:0] enc_carry;
    b64e_out_t  pending_chars[$];
    int         fail_count;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    base64_stream_encoder_core DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [6:0] sextet_ascii(input logic [5:0] s);
        int pos;
        pos = 8 * (63 - int'(s));
        return ALPHABET[pos +: 7];
    endfunction

    function automatic void push_char(input logic [6:0] c, input logic fin);
        b64e_out_t r;
        r.out_char    = c;
        r.end_of_text = fin;
        pending_chars.push_back(r);
    endfunction

    // advance the encoder state by one byte and queue the characters it yields
    function automatic void encode_byte(input b64e_in_t item);
        logic [7:0] b;
        logic       fin;
        b   = item.data_byte;
        fin = item.last_byte;
        if (enc_phase == PHASE_ONE)
        begin
            push_char(sextet_ascii({enc_carry[1:0], b[7:4]}), 1'b0);
            if (fin)
            begin
                push_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
                push_char(PAD_CHAR, 1'b1);
                enc_phase = PHASE_ZERO;
                enc_carry = '0;
            end
            else
            begin
                enc_phase = PHASE_TWO;
                enc_carry = b[3:0];
            end
        end
        else if (enc_phase == PHASE_TWO)
        begin
            push_char(sextet_ascii({enc_carry, b[7:6]}), 1'b0);
            push_char(sextet_ascii(b[5:0]), fin);
            enc_phase = PHASE_ZERO;
            enc_carry = '0;
        end
        else
        begin
            push_char(sextet_ascii(b[7:2]), 1'b0);
            if (fin)
            begin
                push_char(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
                push_char(PAD_CHAR, 1'b0);
                push_char(PAD_CHAR, 1'b1);
                enc_phase = PHASE_ZERO;
                enc_carry = '0;
            end
            else
            begin
                enc_phase = PHASE_ONE;
                enc_carry = {2'b00, b[1:0]};
            end
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] d, input logic fin);
        b64e_in_t item;
        item.data_byte = d;
        item.last_byte = fin;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        do
            @(posedge clk);
        while (!byte_ready);
        encode_byte(item);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // plus and slash characters
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // multi-group messages, one ending in phase zero and one in phase one
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic test_random_messages(input int n_bytes, input int s_pct, input int r_pct);
        int sent;
        int len;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(30, 10);
            else
                len = $urandom_range(9, 1);
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(255)), i == len - 1);
            end
            sent += len;
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        char_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char transaction, actual char %0d eot %0b",
                         $time, char_data.out_char, char_data.end_of_text);
                fail_count++;
            end
            else
            begin
                b64e_out_t exp_c;
                exp_c = pending_chars.pop_front();
                if (char_data.out_char !== exp_c.out_char)
                begin
                    $display("%0t: out_char mismatch, expected %0d actual %0d",
                             $time, exp_c.out_char, char_data.out_char);
                    fail_count++;
                end
                if (char_data.end_of_text !== exp_c.end_of_text)
                begin
                    $display("%0t: end_of_text mismatch, expected %0b actual %0b",
                             $time, exp_c.end_of_text, char_data.end_of_text);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        byte_data     = '0;
        char_ready    = 1'b0;
        enc_phase     = PHASE_ZERO;
        enc_carry     = '0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 13;
        recv_idle_pct = 63;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_messages(130, 13, 63);
        test_random_messages(130, 63, 13);
        test_random_messages(140, 0, 0);

        byte_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder_core.sv
sv/b64e_checker.sv
sim/base64_stream_encoder_core_tb.sv
